// File: design/aarm_pkg.sv
// Shared constants, types and helper functions for the axis-angle rotation matrix block.
package aarm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int AXIS_W       = 16;
  localparam int ANGLE_W      = 24;
  localparam int ENTRY_W      = 18;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;

  // brings any 24-bit angle to a nonnegative 25-bit value, 92 full turns
  localparam logic [24:0] ANGLE_BIAS   = 25'd8478720;
  localparam logic [26:0] RAD_PER_UNIT = 27'd74961319;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic signed [22:0] ENTRY_MAX = 23'sd131071;
  localparam logic signed [22:0] ENTRY_MIN = -23'sd131072;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [31:0]       z;
    logic                     flip;
  } req_t;

  typedef struct packed {
    logic signed [32:0]       x;
    logic signed [32:0]       y;
    logic signed [32:0]       z;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic                     flip;
  } cord_t;

  function automatic logic signed [32:0] atan_q30(input int i);
    logic signed [32:0] t;
    unique case (i)
      0: t = 33'sd843314857;
      1: t = 33'sd497837829;
      2: t = 33'sd263043837;
      3: t = 33'sd133525159;
      4: t = 33'sd67021687;
      5: t = 33'sd33543516;
      6: t = 33'sd16775851;
      7: t = 33'sd8388437;
      8: t = 33'sd4194283;
      9: t = 33'sd2097149;
      default: t = 33'sd1 <<< (30 - i);
    endcase
    return t;
  endfunction

  function automatic cord_t cordic_step(input cord_t s, input int i);
    cord_t r;
    r = s;
    if (s.z >= 0) begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - atan_q30(i);
    end else begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + atan_q30(i);
    end
    return r;
  endfunction

  function automatic logic signed [ENTRY_W:0] entry_sat(input logic signed [53:0] q);
    logic signed [53:0] sum;
    logic signed [22:0] r;
    logic               sat;
    logic signed [ENTRY_W-1:0] v;
    sum = q + 54'sd536870912;
    r   = 23'(sum >>> 30);
    sat = 1'b0;
    if (r > ENTRY_MAX) begin
      v = ENTRY_W'(ENTRY_MAX);
      sat = 1'b1;
    end else if (r < ENTRY_MIN) begin
      v = ENTRY_W'(ENTRY_MIN);
      sat = 1'b1;
    end else begin
      v = ENTRY_W'(r);
    end
    return {sat, v};
  endfunction

endpackage

// File: design/axis_angle_rotation_matrix_top.sv
// Top level of the axis-angle rotation matrix generator.
//   channel  dir  width  contents
//   s_*      in   72     axis_x, axis_y, axis_z (Q3.13), angle_deg (1/256 degree)
//   m_*      out  168    r00..r22 (Q6.12, row-major), tuser: saturated
// One request per cycle sustained while m_tready is high; the data passes the front
// stages, the queue and the CORDIC stage chain of the back end.
// Synchronous reset clears the valid bits and the queue pointers and count only.
// The back end stalls as a whole when m_tvalid is high and m_tready is low; the four-entry queue
// lets the front end keep taking requests until it fills.
module axis_angle_rotation_matrix_top import aarm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // axis_x, axis_y, axis_z, angle_deg
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
  output logic [0:0]   m_tuser    // saturated
);

  logic push, q_not_full, pop, q_not_empty;
  req_t push_data, pop_data;
  logic [9*ENTRY_W-1:0] entries;
  logic sat;

  aarm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .axis_x    (signed'(s_tdata[15:0])),
    .axis_y    (signed'(s_tdata[31:16])),
    .axis_z    (signed'(s_tdata[47:32])),
    .angle_deg (signed'(s_tdata[71:48])),
    .push      (push),
    .q_ready   (q_not_full),
    .push_data (push_data)
  );

  aarm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  aarm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .pop       (pop),
    .q_data    (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .entries   (entries),
    .saturated (sat)
  );

  assign m_tdata = {6'd0, entries};
  assign m_tuser = sat;

endmodule

// File: design/aarm_front.sv
// Front end: accepts requests, reduces and folds the angle, converts it to radians.
module aarm_front import aarm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [AXIS_W-1:0] axis_x,
  input  logic signed [AXIS_W-1:0] axis_y,
  input  logic signed [AXIS_W-1:0] axis_z,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  output logic                     push,
  input  logic                     q_ready,
  output req_t                     push_data
);

  logic [5:0] vld;
  logic       en;

  logic signed [AXIS_W-1:0] ax [6];
  logic signed [AXIS_W-1:0] ay [6];
  logic signed [AXIS_W-1:0] az [6];

  logic [24:0] u1;
  logic [20:0] u2;
  logic [16:0] m3;
  logic [14:0] mag4;
  logic        neg4, neg5;
  logic        flip4, flip5, flip6;
  logic [41:0] prod5;
  logic signed [31:0] z6;

  logic [24:0] r2;
  logic [20:0] r3;
  logic signed [17:0] d4;
  logic        flip_c;
  logic [31:0] zmag;
  logic signed [24:0] ang_ext;

  assign en       = !(vld[5] && !q_ready);
  assign in_ready = en;
  assign push     = vld[5] && q_ready;
  assign ang_ext  = 25'(angle_deg);

  always_comb begin
    r2 = u1;
    for (int k = 7; k >= 4; k--) begin
      if (r2 >= 25'(FULL_TURN << k)) r2 = r2 - 25'(FULL_TURN << k);
    end
    r3 = u2;
    for (int k = 3; k >= 0; k--) begin
      if (r3 >= 21'(FULL_TURN << k)) r3 = r3 - 21'(FULL_TURN << k);
    end
  end

  always_comb begin
    flip_c = 1'b0;
    if (m3 > 17'(QUARTER_TURN) && m3 < 17'(FULL_TURN - QUARTER_TURN)) begin
      d4 = signed'({1'b0, m3}) - 18'sd46080;
      flip_c = 1'b1;
    end else if (m3 >= 17'(FULL_TURN - QUARTER_TURN)) begin
      d4 = signed'({1'b0, m3}) - 18'sd92160;
    end else begin
      d4 = signed'({1'b0, m3});
    end
  end

  assign zmag = 32'((prod5 + 42'd512) >> 10);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1    <= unsigned'(ang_ext) + ANGLE_BIAS;
      ax[0] <= axis_x;
      ay[0] <= axis_y;
      az[0] <= axis_z;
      for (int k = 1; k < 6; k++) begin
        ax[k] <= ax[k-1];
        ay[k] <= ay[k-1];
        az[k] <= az[k-1];
      end
      u2    <= r2[20:0];
      m3    <= r3[16:0];
      mag4  <= d4[17] ? 15'(-d4) : 15'(d4);
      neg4  <= d4[17];
      flip4 <= flip_c;
      prod5 <= 42'(mag4) * 42'(RAD_PER_UNIT);
      neg5  <= neg4;
      flip5 <= flip4;
      z6    <= neg5 ? -signed'(zmag) : signed'(zmag);
      flip6 <= flip5;
    end
  end

  assign push_data = '{axis_x: ax[5], axis_y: ay[5], axis_z: az[5], z: z6, flip: flip6};

endmodule

// File: design/aarm_queue.sv
// Short request queue between the front and back ends.
module aarm_queue import aarm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output req_t pop_data
);

  req_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign not_full  = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count not incremented");
  a_cnt_dec: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("queue count not decremented");

endmodule

// File: design/aarm_back.sv
// Back end: pipelined CORDIC, product tree, rounding and saturation, output register.
module aarm_back import aarm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic pop,
  input  req_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [9*ENTRY_W-1:0] entries,
  output logic saturated
);

  localparam int NV = CORDIC_STEPS + 4;

  logic [NV:0] vld;
  logic        en;
  cord_t       cs [CORDIC_STEPS+1];

  logic signed [18:0] c16, s16;
  logic signed [AXIS_W-1:0] p0x, p0y, p0z;
  logic signed [32:0] xf, yf;

  logic signed [19:0] omc;
  logic signed [44:0] cd1, cd2;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [34:0] sx1, sy1, sz1, sx2, sy2, sz2;
  logic signed [51:0] txx, tyy, tzz, txy, txz, tyz;

  logic signed [53:0] q [9];
  logic [ENTRY_W:0]   e [9];
  logic [8:0]         sat_v;

  assign en        = !out_valid || out_ready;
  assign pop       = en && q_valid;
  assign out_valid = vld[NV];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs[0] <= '{x: CORDIC_GAIN, y: '0, z: 33'(q_data.z), axis_x: q_data.axis_x,
                 axis_y: q_data.axis_y, axis_z: q_data.axis_z, flip: q_data.flip};
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) cs[k+1] <= cordic_step(cs[k], k);
    end
  end

  assign xf = cs[CORDIC_STEPS].flip ? -cs[CORDIC_STEPS].x : cs[CORDIC_STEPS].x;
  assign yf = cs[CORDIC_STEPS].flip ? -cs[CORDIC_STEPS].y : cs[CORDIC_STEPS].y;

  always_comb begin
    q[0] = 54'(cd2) + 54'(txx);
    q[1] = 54'(txy) - (54'(sz2) <<< 13);
    q[2] = 54'(txz) + (54'(sy2) <<< 13);
    q[3] = 54'(txy) + (54'(sz2) <<< 13);
    q[4] = 54'(cd2) + 54'(tyy);
    q[5] = 54'(tyz) - (54'(sx2) <<< 13);
    q[6] = 54'(txz) - (54'(sy2) <<< 13);
    q[7] = 54'(tyz) + (54'(sx2) <<< 13);
    q[8] = 54'(cd2) + 54'(tzz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c16 <= 19'((xf + 33'sd8192) >>> 14);
      s16 <= 19'((yf + 33'sd8192) >>> 14);
      p0x <= cs[CORDIC_STEPS].axis_x;
      p0y <= cs[CORDIC_STEPS].axis_y;
      p0z <= cs[CORDIC_STEPS].axis_z;

      omc <= 20'sd65536 - 20'(c16);
      cd1 <= 45'(c16) <<< 26;
      pxx <= p0x * p0x;
      pyy <= p0y * p0y;
      pzz <= p0z * p0z;
      pxy <= p0x * p0y;
      pxz <= p0x * p0z;
      pyz <= p0y * p0z;
      sx1 <= 35'(s16) * 35'(p0x);
      sy1 <= 35'(s16) * 35'(p0y);
      sz1 <= 35'(s16) * 35'(p0z);

      txx <= 52'(omc) * 52'(pxx);
      tyy <= 52'(omc) * 52'(pyy);
      tzz <= 52'(omc) * 52'(pzz);
      txy <= 52'(omc) * 52'(pxy);
      txz <= 52'(omc) * 52'(pxz);
      tyz <= 52'(omc) * 52'(pyz);
      cd2 <= cd1;
      sx2 <= sx1;
      sy2 <= sy1;
      sz2 <= sz1;

      for (int k = 0; k < 9; k++) begin
        e[k] <= entry_sat(q[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      entries[k*ENTRY_W +: ENTRY_W] = e[k][ENTRY_W-1:0];
      sat_v[k] = e[k][ENTRY_W];
    end
  end

  assign saturated = |sat_v;

endmodule
